/* hdl/plt_pkg.sv */
`timescale 1ns / 1ps

package plt_pkg;

  // Field widths fixed by the interface
  localparam int ID_W     = 64;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int CAPS_W   = 32;
  localparam int TIME_W   = 64;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 5;
  localparam int CNT_W    = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD_SEED = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEARD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HAS_PEER = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 64'd30000;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [CAPS_W-1:0] caps;
    logic              alive;
    logic [TIME_W-1:0] last_seen;
  } plt_entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              tick;     // age entries this cycle
    logic              remove;   // close the gap at the matching cell
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] timeout;
    logic [ID_W-1:0]   key;
    plt_entry_t        wdata;
  } plt_bcast_t;

endpackage

/* hdl/plt_cell.sv */
`timescale 1ns / 1ps

// One table slot: key compare, ageing and shift-down from the right neighbour.
module plt_cell (
  input  logic                clk_i,
  input  plt_pkg::plt_bcast_t bc_i,
  input  logic                occ_i,
  input  logic                wr_i,
  input  logic                chain_i,
  input  plt_pkg::plt_entry_t next_i,
  output logic                chain_o,
  output logic                match_o,
  output plt_pkg::plt_entry_t entry_o
);

  plt_pkg::plt_entry_t         entry_q, entry_d;
  logic [plt_pkg::TIME_W-1:0]  elapsed;
  logic                        stale;

  assign match_o = occ_i && (entry_q.id == bc_i.key);
  // set from the matching slot rightwards
  assign chain_o = chain_i || match_o;

  assign elapsed = bc_i.now - entry_q.last_seen;
  assign stale   = elapsed > bc_i.timeout;

  always_comb begin
    entry_d = entry_q;
    if (bc_i.remove && chain_o) begin
      entry_d = next_i;
    end else if (wr_i) begin
      entry_d = bc_i.wdata;
    end else if (bc_i.tick && stale) begin
      entry_d.alive = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* hdl/peer_liveness_table_top.sv */
`timescale 1ns / 1ps

// Peer liveness table: up to MAX_PEERS peers keyed by a 64-bit id, kept in
// insertion order in a row of slot cells.
// Input channel (in_valid_i / in_stall_o): one command per transaction -
// add seed, heard peer, tick, remove, has peer or read entry.
// Output channel (out_valid_o / out_stall_i): exactly one result per command,
// carrying status, found, the read fields and the peer and alive counts.
// A command passes through S_IDLE (accept), then S_EXEC, in which every cell
// compares, ages or shifts in parallel, then S_COUNT and S_SUM for the alive
// count (registered per-byte popcounts, then their sum). No new command is
// taken until the block is back in S_IDLE.
// A stalled result holds in the output register; the next command is taken
// and executed meanwhile and waits in the last step until that register frees.
// cfg_we_i writes the timeout (ms) from cfg_wdata_i; write it only while idle (not enforced).
// Reset empties the table, clears the stored time, sets the timeout to
// 30000 ms and drops any pending result. No clearing pass is needed.
module peer_liveness_table_top #(
  parameter int MAX_PEERS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [plt_pkg::TIME_W-1:0]      cfg_wdata_i,
  // command channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [plt_pkg::CMD_W-1:0]       cmd_i,
  input  logic [plt_pkg::ID_W-1:0]        peer_id_i,
  input  logic [plt_pkg::ADDR_W-1:0]      peer_addr_i,
  input  logic [plt_pkg::PORT_W-1:0]      peer_port_i,
  input  logic [plt_pkg::CAPS_W-1:0]      peer_caps_i,
  input  logic [plt_pkg::TIME_W-1:0]      time_ms_i,
  input  logic [plt_pkg::INDEX_W-1:0]     entry_index_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [plt_pkg::STATUS_W-1:0]    status_o,
  output logic                            found_o,
  output logic [plt_pkg::CNT_W-1:0]       peer_count_o,
  output logic [plt_pkg::CNT_W-1:0]       alive_count_o,
  output logic [plt_pkg::ID_W-1:0]        read_id_o,
  output logic [plt_pkg::ADDR_W-1:0]      read_addr_o,
  output logic [plt_pkg::PORT_W-1:0]      read_port_o,
  output logic [plt_pkg::CAPS_W-1:0]      read_caps_o,
  output logic                            read_alive_o,
  output logic [plt_pkg::TIME_W-1:0]      read_last_seen_o
);

  localparam int COUNT_W = $clog2(MAX_PEERS + 1);
  localparam int IDX_W   = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int NGRP    = (MAX_PEERS + 7) / 8;
  localparam int GRP_W   = 4;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_COUNT = 2'd2;
  localparam logic [1:0] S_SUM   = 2'd3;

  logic [1:0] state_q, state_d;

  // Registered command
  logic [plt_pkg::CMD_W-1:0]   cmd_q;
  logic [plt_pkg::ID_W-1:0]    id_q;
  logic [plt_pkg::ADDR_W-1:0]  addr_q;
  logic [plt_pkg::PORT_W-1:0]  port_q;
  logic [plt_pkg::CAPS_W-1:0]  caps_q;
  logic [plt_pkg::TIME_W-1:0]  time_q;
  logic [plt_pkg::INDEX_W-1:0] idx_q;

  // Table control state
  logic [COUNT_W-1:0]         used_count_q, used_count_d;
  logic [plt_pkg::TIME_W-1:0] now_ms_q, now_ms_d;
  logic [plt_pkg::TIME_W-1:0] timeout_q;

  // Per-command result held until the count is ready
  logic [plt_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                         res_found_q, res_found_d;
  plt_pkg::plt_entry_t          res_read_q, res_read_d;

  // Output register
  logic                         out_valid_q;
  logic [plt_pkg::STATUS_W-1:0] out_status_q;
  logic                         out_found_q;
  logic [plt_pkg::CNT_W-1:0]    out_peer_q, out_alive_q;
  plt_pkg::plt_entry_t          out_read_q;

  // Cell row
  plt_pkg::plt_bcast_t bc;
  plt_pkg::plt_entry_t entries [MAX_PEERS];
  logic [MAX_PEERS-1:0] occ, match_vec, append_vec, wr_vec;
  logic [MAX_PEERS:0]   chain;
  logic [NGRP*8-1:0]    live;

  logic [GRP_W-1:0]   grp_q [NGRP];
  logic [GRP_W-1:0]   grp_d [NGRP];
  logic [COUNT_W-1:0] alive_sum;

  logic               accept, full, hit, rd_ok, out_free;
  logic [IDX_W-1:0]   rd_sel;
  logic [31:0]        idx_ext;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------
  // Slot cells; the remove marker ripples left to right along the row.
  // ---------------------------------------------------------------------
  assign chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_PEERS; i++) begin : g_cell
    plt_pkg::plt_entry_t next_entry;

    assign occ[i]        = COUNT_W'(i) < used_count_q;
    assign append_vec[i] = COUNT_W'(i) == used_count_q;
    assign live[i]       = occ[i] && entries[i].alive;

    if (i < MAX_PEERS - 1) begin : g_mid
      assign next_entry = entries[i+1];
    end else begin : g_last
      assign next_entry = entries[i];   // vacated slot; contents don't care
    end

    plt_cell u_cell (
      .clk_i   (clk_i),
      .bc_i    (bc),
      .occ_i   (occ[i]),
      .wr_i    (wr_vec[i]),
      .chain_i (chain[i]),
      .next_i  (next_entry),
      .chain_o (chain[i+1]),
      .match_o (match_vec[i]),
      .entry_o (entries[i])
    );
  end

  for (genvar p = MAX_PEERS; p < NGRP * 8; p++) begin : g_pad
    assign live[p] = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Command execution (S_EXEC)
  // ---------------------------------------------------------------------
  assign full    = (used_count_q == COUNT_W'(MAX_PEERS));
  assign hit     = |match_vec;
  assign idx_ext = 32'(idx_q);
  // used_count never exceeds MAX_PEERS, so this also bounds the slot index
  assign rd_ok   = idx_ext < 32'(used_count_q);
  assign rd_sel  = idx_ext[IDX_W-1:0];

  always_comb begin
    bc.tick            = 1'b0;
    bc.remove          = 1'b0;
    bc.now             = time_q;
    bc.timeout         = timeout_q;
    bc.key             = id_q;
    bc.wdata.id        = id_q;
    bc.wdata.addr      = addr_q;
    bc.wdata.port      = port_q;
    bc.wdata.caps      = caps_q;
    bc.wdata.alive     = 1'b1;
    bc.wdata.last_seen = now_ms_q;
    wr_vec             = '0;
    used_count_d       = used_count_q;
    now_ms_d           = now_ms_q;
    res_status_d       = res_status_q;
    res_found_d        = res_found_q;
    res_read_d         = res_read_q;

    if (state_q == S_EXEC) begin
      res_status_d = plt_pkg::ST_OK;
      res_found_d  = 1'b0;
      res_read_d   = '0;
      unique case (cmd_q)
        plt_pkg::CMD_ADD_SEED: begin
          // seeds start dead with no history or capabilities
          bc.wdata.caps      = '0;
          bc.wdata.alive     = 1'b0;
          bc.wdata.last_seen = '0;
          if (full) begin
            res_status_d = plt_pkg::ST_FULL;
          end else if (!hit) begin
            wr_vec       = append_vec;
            used_count_d = used_count_q + COUNT_W'(1);
          end
        end
        plt_pkg::CMD_HEARD: begin
          if (hit) begin
            wr_vec = match_vec;
          end else if (full) begin
            res_status_d = plt_pkg::ST_FULL;
          end else begin
            wr_vec       = append_vec;
            used_count_d = used_count_q + COUNT_W'(1);
          end
        end
        plt_pkg::CMD_TICK: begin
          bc.tick  = 1'b1;
          now_ms_d = time_q;
        end
        plt_pkg::CMD_REMOVE: begin
          if (hit) begin
            bc.remove    = 1'b1;
            used_count_d = used_count_q - COUNT_W'(1);
          end else begin
            res_status_d = plt_pkg::ST_NOT_FOUND;
          end
        end
        plt_pkg::CMD_HAS_PEER: begin
          res_found_d = hit;
        end
        plt_pkg::CMD_READ: begin
          if (rd_ok) begin
            res_read_d = entries[rd_sel];
          end else begin
            res_status_d = plt_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
          // unused codes: no change, status ok
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Alive count: per-byte popcounts (S_COUNT), then their sum (S_SUM)
  // ---------------------------------------------------------------------
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_d[g] = grp_d[g] + GRP_W'(live[g*8+b]);
      end
    end
  end

  always_comb begin
    alive_sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      alive_sum = alive_sum + COUNT_W'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COUNT) begin
      grp_q <= grp_d;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = S_COUNT;
      S_COUNT: state_d = S_SUM;
      S_SUM:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_count_q <= '0;
      now_ms_q     <= '0;
      timeout_q    <= plt_pkg::TIMEOUT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_count_q <= used_count_d;
      now_ms_q     <= now_ms_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (state_q == S_SUM && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      id_q   <= peer_id_i;
      addr_q <= peer_addr_i;
      port_q <= peer_port_i;
      caps_q <= peer_caps_i;
      time_q <= time_ms_i;
      idx_q  <= entry_index_i;
    end
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_read_q   <= res_read_d;
    if (state_q == S_SUM && out_free) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_peer_q   <= plt_pkg::CNT_W'(used_count_q);
      out_alive_q  <= plt_pkg::CNT_W'(alive_sum);
      out_read_q   <= res_read_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_o          = out_found_q;
  assign peer_count_o     = out_peer_q;
  assign alive_count_o    = out_alive_q;
  assign read_id_o        = out_read_q.id;
  assign read_addr_o      = out_read_q.addr;
  assign read_port_o      = out_read_q.port;
  assign read_caps_o      = out_read_q.caps;
  assign read_alive_o     = out_read_q.alive;
  assign read_last_seen_o = out_read_q.last_seen;

`ifndef SYNTHESIS
  // Never more entries than slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q <= COUNT_W'(MAX_PEERS))
    else $error("peer count beyond table size");

  // Ids in the table are unique, so at most one slot matches
  a_unique_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("duplicate id in table");

  // A command goes straight into execution
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted command not executed");

  // One command moves the peer count by at most one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> (used_count_q == $past(used_count_q)) ||
                          (used_count_q == $past(used_count_q) + COUNT_W'(1)) ||
                          (used_count_q == $past(used_count_q) - COUNT_W'(1)))
    else $error("peer count jumped");

  // The table only changes while a command executes
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_EXEC |=> $stable(used_count_q))
    else $error("peer count changed outside execution");
`endif

endmodule

/* tb/sv/peer_liveness_table_top_test.sv */
`timescale 1ns / 1ps

module peer_liveness_table_top_test;
  import plt_pkg::*;

  localparam int TBL_DEPTH    = 32;
  localparam int ID_POOL      = 40;   // a little over the depth, so the table can fill
  localparam int N_PHASES     = 5;
  localparam int SHOWN_FAULTS = 10;

  // command codes outside the defined set; the block must leave the table alone
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic [ID_W-1:0]   ID_ONES   = '1;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [PORT_W-1:0] PORT_ONES = '1;
  localparam logic [CAPS_W-1:0] CAPS_ONES = '1;
  localparam logic [ID_W-1:0]   ID_MSB_LSB = 64'h8000_0000_0000_0001;

  // one command transaction as seen on the input ports
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [CAPS_W-1:0]  caps;
    logic [TIME_W-1:0]  tms;
    logic [INDEX_W-1:0] idx;
  } peer_cmd_t;

  // one result transaction; rd mirrors the read_* ports
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [CNT_W-1:0]    peers;
    logic [CNT_W-1:0]    alive_n;
    plt_entry_t          rd;
  } peer_reply_t;

  // directed row: pinned rows carry a hand-written answer, the rest use the predictor
  typedef struct packed {
    peer_cmd_t           cmd;
    logic                pinned;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [CNT_W-1:0]    peers;
    logic [CNT_W-1:0]    alive_n;
  } stim_row_t;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} cmd_mix_e;

  // cumulative percentages for add, heard, tick, remove, has, read; the rest spare codes
  int mix_cut [3][6] = '{'{30, 65, 75, 80, 88, 98},
                         '{15, 40, 55, 75, 85, 98},
                         '{ 5, 15, 25, 75, 85, 98}};
  logic [CMD_W-1:0] cmd_order [6] = '{CMD_ADD_SEED, CMD_HEARD, CMD_TICK,
                                      CMD_REMOVE, CMD_HAS_PEER, CMD_READ};

  // DUT ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [TIME_W-1:0]     cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i;
  logic [ID_W-1:0]       peer_id_i;
  logic [ADDR_W-1:0]     peer_addr_i;
  logic [PORT_W-1:0]     peer_port_i;
  logic [CAPS_W-1:0]     peer_caps_i;
  logic [TIME_W-1:0]     time_ms_i;
  logic [INDEX_W-1:0]    entry_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [STATUS_W-1:0]   status_o;
  logic                  found_o;
  logic [CNT_W-1:0]      peer_count_o;
  logic [CNT_W-1:0]      alive_count_o;
  logic [ID_W-1:0]       read_id_o;
  logic [ADDR_W-1:0]     read_addr_o;
  logic [PORT_W-1:0]     read_port_o;
  logic [CAPS_W-1:0]     read_caps_o;
  logic                  read_alive_o;
  logic [TIME_W-1:0]     read_last_seen_o;

  // shadow copy of the table, advanced once per accepted command
  plt_entry_t        peer_rows [TBL_DEPTH];
  int                row_count     = 0;
  logic [TIME_W-1:0] table_now     = '0;
  logic [TIME_W-1:0] table_timeout = TIMEOUT_RST;

  peer_reply_t       awaited_replies [$];
  logic [ID_W-1:0]   peer_ids [ID_POOL];
  int                fault_count = 0;
  logic              steady_run  = 1'b0;   // high: neither side idles

  peer_liveness_table_top #(
    .MAX_PEERS (TBL_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .peer_id_i        (peer_id_i),
    .peer_addr_i      (peer_addr_i),
    .peer_port_i      (peer_port_i),
    .peer_caps_i      (peer_caps_i),
    .time_ms_i        (time_ms_i),
    .entry_index_i    (entry_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_o          (found_o),
    .peer_count_o     (peer_count_o),
    .alive_count_o    (alive_count_o),
    .read_id_o        (read_id_o),
    .read_addr_o      (read_addr_o),
    .read_port_o      (read_port_o),
    .read_caps_o      (read_caps_o),
    .read_alive_o     (read_alive_o),
    .read_last_seen_o (read_last_seen_o)
  );

  // 12 ns period
  always #6 clk_i = ~clk_i;

  // receiver back-pressure, independent of everything the block does
  always @(posedge clk_i) begin
    out_stall_i <= !steady_run && ($urandom_range(0, 99) < 18);
  end

  function automatic int locate_peer(logic [ID_W-1:0] key);
    for (int i = 0; i < row_count; i++) begin
      if (peer_rows[i].id == key) return i;
    end
    return -1;
  endfunction

  // Applies one command to the shadow table and returns the result it must give.
  function automatic peer_reply_t peer_table_step(peer_cmd_t c);
    peer_reply_t r;
    plt_entry_t  e;
    int          pos;
    int          live;
    r    = '0;
    live = 0;
    pos  = locate_peer(c.id);
    // heard-peer entry; a seed overrides caps, alive and time below
    e.id        = c.id;
    e.addr      = c.addr;
    e.port      = c.port;
    e.caps      = c.caps;
    e.alive     = 1'b1;
    e.last_seen = table_now;
    case (c.cmd)
      CMD_ADD_SEED: begin
        // full wins over the duplicate check
        if (row_count >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else if (pos < 0) begin
          e.caps      = '0;
          e.alive     = 1'b0;
          e.last_seen = '0;
          peer_rows[row_count] = e;
          row_count++;
        end
      end
      CMD_HEARD: begin
        if (pos >= 0) begin
          peer_rows[pos] = e;
        end else if (row_count >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          peer_rows[row_count] = e;
          row_count++;
        end
      end
      CMD_TICK: begin
        table_now = c.tms;
        // elapsed time wraps modulo 2^64
        for (int i = 0; i < row_count; i++) begin
          if (peer_rows[i].alive && (c.tms - peer_rows[i].last_seen) > table_timeout)
            peer_rows[i].alive = 1'b0;
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < row_count; i++) peer_rows[i] = peer_rows[i + 1];
          row_count--;
        end
      end
      CMD_HAS_PEER: r.found = (pos >= 0);
      CMD_READ: begin
        if (int'(c.idx) < row_count) r.rd = peer_rows[c.idx];
        else r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    for (int i = 0; i < row_count; i++) begin
      if (peer_rows[i].alive) live++;
    end
    r.peers   = CNT_W'(row_count);
    r.alive_n = CNT_W'(live);
    return r;
  endfunction

  function automatic stim_row_t stim_row(
    logic [CMD_W-1:0] c, logic [ID_W-1:0] id, logic [ADDR_W-1:0] addr,
    logic [PORT_W-1:0] port, logic [CAPS_W-1:0] caps, logic [TIME_W-1:0] tms,
    logic [INDEX_W-1:0] idx, logic pinned, logic [STATUS_W-1:0] st, logic fd,
    logic [CNT_W-1:0] pc, logic [CNT_W-1:0] ac);
    stim_row_t r;
    r.cmd.cmd  = c;
    r.cmd.id   = id;
    r.cmd.addr = addr;
    r.cmd.port = port;
    r.cmd.caps = caps;
    r.cmd.tms  = tms;
    r.cmd.idx  = idx;
    r.pinned   = pinned;
    r.status   = st;
    r.found    = fd;
    r.peers    = pc;
    r.alive_n  = ac;
    return r;
  endfunction

  // Presents one command and holds it until the transaction completes, then
  // queues the answer it must produce. Called just after a rising edge.
  task automatic send_item(peer_cmd_t c, logic pinned, peer_reply_t pinned_reply);
    peer_reply_t modelled;
    cmd_i         <= c.cmd;
    peer_id_i     <= c.id;
    peer_addr_i   <= c.addr;
    peer_port_i   <= c.port;
    peer_caps_i   <= c.caps;
    time_ms_i     <= c.tms;
    entry_index_i <= c.idx;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    modelled = peer_table_step(c);
    awaited_replies.push_back(pinned ? pinned_reply : modelled);
  endtask

  // random sender gap, roughly 18 times in a hundred
  task automatic pause_sender();
    if (!steady_run && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= SHOWN_FAULTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // result monitor: every completed result transaction is matched in order
  always @(posedge clk_i) begin
    peer_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
          $display("%0t: result transaction with nothing outstanding", $time);
      end else begin
        want = awaited_replies.pop_front();
        check_field("status",         want.status,       status_o);
        check_field("found",          want.found,        found_o);
        check_field("peer_count",     want.peers,        peer_count_o);
        check_field("alive_count",    want.alive_n,      alive_count_o);
        check_field("read_id",        want.rd.id,        read_id_o);
        check_field("read_addr",      want.rd.addr,      read_addr_o);
        check_field("read_port",      want.rd.port,      read_port_o);
        check_field("read_caps",      want.rd.caps,      read_caps_o);
        check_field("read_alive",     want.rd.alive,     read_alive_o);
        check_field("read_last_seen", want.rd.last_seen, read_last_seen_o);
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t         rows [$];
    peer_cmd_t         c;
    peer_reply_t       pin;
    cmd_mix_e          mix;
    int                roll;
    int                phase_items [N_PHASES];
    logic [TIME_W-1:0] phase_timeout [N_PHASES];
    logic [TIME_W-1:0] step_mask [N_PHASES];
    logic [TIME_W-1:0] tick_clock;

    // everything known from time zero; reset held low at the start
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_HAS_PEER;
    peer_id_i     <= '0;
    peer_addr_i   <= '0;
    peer_port_i   <= '0;
    peer_caps_i   <= '0;
    time_ms_i     <= '0;
    entry_index_i <= '0;
    out_stall_i   <= 1'b0;

    // id pool with both extremes; duplicates, hits and a full table all come easily
    peer_ids[0] = '0;
    peer_ids[1] = ID_ONES;
    for (int i = 2; i < ID_POOL; i++) peer_ids[i] = {$urandom, $urandom};

    // per phase: timeout, length and how far the clock moves per tick
    phase_timeout = '{64'd0, ID_ONES, 64'd40, {$urandom, $urandom}, TIMEOUT_RST};
    phase_items   = '{150, 200, 250, 150, 250};
    step_mask     = '{64'h3, ID_ONES, 64'h3F, ID_ONES, 64'h7FFF};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset timeout of 30000 ms. Pinned rows spell the answer out.
    // empty table: query, read and remove all miss
    rows.push_back(stim_row(CMD_HAS_PEER, '0, '0, '0, '0, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd0, 6'd0));
    rows.push_back(stim_row(CMD_READ, '0, '0, '0, '0, '0, '0,
                            1'b1, ST_NOT_FOUND, 1'b0, 6'd0, 6'd0));
    rows.push_back(stim_row(CMD_REMOVE, ID_ONES, '0, '0, '0, '0, '0,
                            1'b1, ST_NOT_FOUND, 1'b0, 6'd0, 6'd0));
    // seeds at both extremes; seeded caps are dropped
    rows.push_back(stim_row(CMD_ADD_SEED, '0, '0, '0, CAPS_ONES, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd1, 6'd0));
    rows.push_back(stim_row(CMD_ADD_SEED, ID_ONES, ADDR_ONES, PORT_ONES, CAPS_ONES, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd2, 6'd0));
    // seed with a known id leaves the entry as it was
    rows.push_back(stim_row(CMD_ADD_SEED, '0, 32'h1234, 16'h55, '0, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd2, 6'd0));
    rows.push_back(stim_row(CMD_READ, '0, '0, '0, '0, '0, 5'd1,
                            1'b0, ST_OK, 1'b0, '0, '0));
    // heard: update of a seed, then a new peer
    rows.push_back(stim_row(CMD_HEARD, ID_ONES, ADDR_ONES, PORT_ONES, CAPS_ONES, ID_ONES, '0,
                            1'b1, ST_OK, 1'b0, 6'd2, 6'd1));
    rows.push_back(stim_row(CMD_HEARD, ID_MSB_LSB, '0, '0, '0, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd3, 6'd2));
    // ageing: exactly the timeout survives, one more ms does not
    rows.push_back(stim_row(CMD_TICK, '0, '0, '0, '0, 64'd30000, '0,
                            1'b1, ST_OK, 1'b0, 6'd3, 6'd2));
    rows.push_back(stim_row(CMD_TICK, '0, '0, '0, '0, 64'd30001, '0,
                            1'b1, ST_OK, 1'b0, 6'd3, 6'd0));
    rows.push_back(stim_row(CMD_HEARD, '0, 32'hC0A8_0001, 16'd1234, 32'h5, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd3, 6'd1));
    rows.push_back(stim_row(CMD_READ, '0, '0, '0, '0, '0, 5'd0,
                            1'b0, ST_OK, 1'b0, '0, '0));
    // time going backwards wraps to a huge elapsed time
    rows.push_back(stim_row(CMD_TICK, '0, '0, '0, '0, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd3, 6'd0));
    rows.push_back(stim_row(CMD_HEARD, ID_ONES, ADDR_ONES, PORT_ONES, CAPS_ONES, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd3, 6'd1));
    rows.push_back(stim_row(CMD_TICK, '0, '0, '0, '0, ID_ONES, '0,
                            1'b1, ST_OK, 1'b0, 6'd3, 6'd0));
    // remove at the head, then read what shifted down
    rows.push_back(stim_row(CMD_REMOVE, '0, '0, '0, '0, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd2, 6'd0));
    rows.push_back(stim_row(CMD_READ, '0, '0, '0, '0, '0, 5'd0,
                            1'b0, ST_OK, 1'b0, '0, '0));
    rows.push_back(stim_row(CMD_READ, '0, '0, '0, '0, '0, 5'd31,
                            1'b1, ST_NOT_FOUND, 1'b0, 6'd2, 6'd0));
    // spare command codes do nothing
    rows.push_back(stim_row(CMD_SPARE_6, ID_ONES, '0, '0, '0, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd2, 6'd0));
    rows.push_back(stim_row(CMD_SPARE_7, '0, '0, '0, '0, '0, 5'd31,
                            1'b1, ST_OK, 1'b0, 6'd2, 6'd0));
    rows.push_back(stim_row(CMD_HAS_PEER, ID_ONES, '0, '0, '0, '0, '0,
                            1'b1, ST_OK, 1'b1, 6'd2, 6'd0));
    // remove at the tail
    rows.push_back(stim_row(CMD_REMOVE, ID_MSB_LSB, '0, '0, '0, '0, '0,
                            1'b1, ST_OK, 1'b0, 6'd1, 6'd0));
    rows.push_back(stim_row(CMD_READ, '0, '0, '0, '0, '0, 5'd0,
                            1'b0, ST_OK, 1'b0, '0, '0));

    for (int k = 0; k < rows.size(); k++) begin
      if (k > 0) pause_sender();
      pin         = '0;
      pin.status  = rows[k].status;
      pin.found   = rows[k].found;
      pin.peers   = rows[k].peers;
      pin.alive_n = rows[k].alive_n;
      send_item(rows[k].cmd, rows[k].pinned, pin);
    end
    in_valid_i <= 1'b0;

    // Random phases, each under its own timeout: fill the table, churn it,
    // and in the last phase drain it. Phase 2 runs with no idling on either side.
    tick_clock = '0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      // timeout only changes with nothing in flight
      while (awaited_replies.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      cfg_wdata_i   <= phase_timeout[ph];
      cfg_we_i      <= 1'b1;
      steady_run    <= (ph == 2);
      @(posedge clk_i);
      cfg_we_i      <= 1'b0;
      table_timeout = phase_timeout[ph];

      for (int k = 0; k < phase_items[ph]; k++) begin
        if (k > 0) pause_sender();
        if (ph == N_PHASES - 1)
          mix = (k * 5 >= phase_items[ph] * 3) ? MIX_DRAIN : MIX_CHURN;
        else
          mix = (k * 5 < phase_items[ph] * 2) ? MIX_FILL : MIX_CHURN;

        roll  = $urandom_range(0, 99);
        c.cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        for (int j = 5; j >= 0; j--) begin
          if (roll < mix_cut[mix][j]) c.cmd = cmd_order[j];
        end

        // mostly pool ids; the odd stray id mostly misses
        c.id   = ($urandom_range(0, 99) < 85) ? peer_ids[$urandom_range(0, ID_POOL - 1)]
                                              : {$urandom, $urandom};
        c.addr = $urandom;
        c.port = PORT_W'($urandom);
        c.caps = $urandom;
        if ($urandom_range(0, 4) != 0)
          c.idx = INDEX_W'($urandom_range(0, (row_count < TBL_DEPTH) ? row_count
                                                                     : TBL_DEPTH - 1));
        else
          c.idx = INDEX_W'($urandom);

        // ticks follow a running clock with the occasional jump anywhere
        if (c.cmd == CMD_TICK) begin
          if ($urandom_range(0, 99) < 4) tick_clock = {$urandom, $urandom};
          else tick_clock = tick_clock + ({$urandom, $urandom} & step_mask[ph]);
          c.tms = tick_clock;
        end else begin
          c.tms = {$urandom, $urandom};
        end

        send_item(c, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    steady_run <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
